// ===== sv/dvrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the distance-vector route table.
// Used by dvrt_ctrl, dvrt_dpath and distance_vector_route_table_core; no dependencies.
package dvrt_pkg;

  parameter int NODE_COUNT_DEF = 16;

  parameter int CFG_ADDR_W = 3;
  parameter logic REG_SELF_INDEX = 1'b0;
  parameter logic [3:0] SELF_INDEX_RESET = 4'd1;

  parameter logic [11:0] DIST_INF = 12'd2000;
  parameter logic [9:0] MAX_LINK_COST = 10'd1000;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_RECOMP = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_LOAD    = 3'd2,
    OP_COST_RD = 3'd3,
    OP_COST_WR = 3'd4,
    OP_ROW     = 3'd5,
    OP_SWEEP   = 3'd6,
    OP_READ    = 3'd7
  } dp_op_t;

  typedef struct packed {
    logic [3:0]  hop;
    logic [10:0] dis;
  } route_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   cnt_clr;
    logic   cnt_inc;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last_row;
    logic cnt_last_all;
    logic upd_skip;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/dvrt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the route table: sequences commands into datapath operations.
// Depends on dvrt_pkg.
module dvrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_stall,
  input  dvrt_pkg::dp_stat_t  stat,
  output dvrt_pkg::dp_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_LOAD    = 11'b000_0000_0100,
    S_COST_RD = 11'b000_0000_1000,
    S_COST_WR = 11'b000_0001_0000,
    S_ROW     = 11'b000_0010_0000,
    S_REBUILD = 11'b000_0100_0000,
    S_RECOMP  = 11'b000_1000_0000,
    S_DRAIN   = 11'b001_0000_0000,
    S_READ    = 11'b010_0000_0000,
    S_RESP    = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = dvrt_pkg::OP_NONE;
    cmd.capture  = 1'b0;
    cmd.cnt_clr  = 1'b0;
    cmd.cnt_inc  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op      = dvrt_pkg::OP_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_all) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
          case (dvrt_pkg::cmd_t'(in_command))
            dvrt_pkg::CMD_LOAD:   state_nxt = S_LOAD;
            dvrt_pkg::CMD_UPDATE: state_nxt = S_COST_RD;
            dvrt_pkg::CMD_RECOMP: state_nxt = S_RECOMP;
            dvrt_pkg::CMD_READ:   state_nxt = S_READ;
            default:              state_nxt = S_RESP;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op    = dvrt_pkg::OP_LOAD;
        state_nxt = S_RESP;
      end
      S_COST_RD: begin
        cmd.op    = dvrt_pkg::OP_COST_RD;
        state_nxt = S_COST_WR;
      end
      S_COST_WR: begin
        cmd.op    = dvrt_pkg::OP_COST_WR;
        state_nxt = stat.upd_skip ? S_RESP : S_ROW;
      end
      S_ROW: begin
        cmd.op      = dvrt_pkg::OP_ROW;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_row) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_REBUILD;
        end
      end
      S_REBUILD: begin
        cmd.op      = dvrt_pkg::OP_SWEEP;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_row) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_RECOMP: begin
        cmd.op      = dvrt_pkg::OP_SWEEP;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_all) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        cmd.op    = dvrt_pkg::OP_READ;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A second transaction could be accepted right after the first.");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("The controller did not return to idle after loading a result.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> !stat.pipe_busy)
    else $error("A result was offered while the sweep pipeline was still busy.");

endmodule

// ===== sv/dvrt_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the route table: link cost, neighbor vector and route memories, the sweep
// pipeline and the result register. Depends on dvrt_pkg.
module dvrt_dpath #(
  parameter int NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dvrt_pkg::dp_cmd_t   cmd,
  output dvrt_pkg::dp_stat_t  stat,
  input  logic [3:0]          self_index,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_neighbor_index,
  input  logic [3:0]          in_dest_index,
  input  logic signed [11:0]  in_vector_distance,
  input  logic [9:0]          in_link_weight,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_changed,
  output logic [3:0]          out_next_hop,
  output logic [10:0]         out_distance
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int VA_W  = 2 * IDX_W;
  localparam int IDX_N = 1 << IDX_W;
  localparam int VA_N  = 1 << VA_W;
  localparam int CW    = (IDX_W > 4) ? IDX_W : 4;

  logic signed [11:0] vec_mem [VA_N];
  logic [9:0]         cost_mem [IDX_N];
  dvrt_pkg::route_t   route_mem [IDX_N];

  dvrt_pkg::cmd_t     cmd_r;
  logic [3:0]         nb_r;
  logic [3:0]         dst_r;
  logic signed [11:0] vd_r;
  logic [9:0]         wt_r;

  logic [VA_W-1:0]    cnt_r;
  logic [VA_W-1:0]    cnt_nxt;

  logic               b_v_r;
  logic [IDX_W-1:0]   b_i_r;
  logic [IDX_W-1:0]   b_j_r;
  logic               c_v_r;
  logic [IDX_W-1:0]   c_i_r;
  logic [11:0]        best_r;
  logic [11:0]        best_nxt;
  logic [IDX_W-1:0]   hop_r;
  logic [IDX_W-1:0]   hop_nxt;
  logic [10:0]        old_r;
  logic [10:0]        old_nxt;
  logic               changed_r;
  logic               changed_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_changed_r;
  logic [3:0]         out_next_hop_r;
  logic [10:0]        out_distance_r;

  logic signed [11:0] vec_q;
  logic [9:0]         cost_q;
  dvrt_pkg::route_t   route_q;

  logic               vec_we;
  logic [VA_W-1:0]    vec_wa;
  logic signed [11:0] vec_wd;
  logic               vec_re;
  logic [VA_W-1:0]    vec_ra;
  logic               cost_we;
  logic [IDX_W-1:0]   cost_wa;
  logic [9:0]         cost_wd;
  logic               cost_re;
  logic [IDX_W-1:0]   cost_ra;
  logic               route_we;
  logic [IDX_W-1:0]   route_wa;
  dvrt_pkg::route_t   route_wd;
  logic               route_re;
  logic [IDX_W-1:0]   route_ra;

  logic [IDX_W-1:0]   nb_idx;
  logic [IDX_W-1:0]   dst_idx;
  logic               nb_ok;
  logic               dst_ok;
  logic               self_ok;
  logic               drop;
  logic               upd_skip;
  logic               rebuild;
  logic               sweep;
  logic [IDX_W-1:0]   cnt_lo;
  logic [IDX_W-1:0]   cnt_hi;
  logic [IDX_W-1:0]   a_i;
  logic [IDX_W-1:0]   a_j;
  logic               j_zero;
  logic               b_i_self;
  logic               b_j_self;
  logic               c_i_self;
  logic [11:0]        cand;
  dvrt_pkg::route_t   reb_entry;
  dvrt_pkg::route_t   fresh;

  assign nb_idx   = IDX_W'(nb_r);
  assign dst_idx  = IDX_W'(dst_r);
  assign nb_ok    = (int'(nb_r) < NODE_COUNT);
  assign dst_ok   = (int'(dst_r) < NODE_COUNT);
  assign self_ok  = (int'(self_index) < NODE_COUNT);
  assign drop     = (wt_r == 10'd0) || (wt_r > dvrt_pkg::MAX_LINK_COST);
  assign upd_skip = !nb_ok || (drop ? (cost_q == 10'd0) : (wt_r == cost_q));
  assign rebuild  = (cmd_r == dvrt_pkg::CMD_UPDATE);
  assign sweep    = (cmd.op == dvrt_pkg::OP_SWEEP);
  assign cnt_lo   = cnt_r[IDX_W-1:0];
  assign cnt_hi   = cnt_r[VA_W-1:IDX_W];
  assign a_i      = rebuild ? cnt_lo : cnt_hi;
  assign a_j      = cnt_lo;
  assign j_zero   = (a_j == '0);

  assign b_i_self = (CW'(b_i_r) == CW'(self_index)) && self_ok;
  assign b_j_self = (CW'(b_j_r) == CW'(self_index));
  assign c_i_self = (CW'(c_i_r) == CW'(self_index)) && self_ok;
  assign cand     = {2'b00, cost_q} + $unsigned(vec_q);

  always_comb begin
    reb_entry = '0;
    if (b_i_r != '0) begin
      reb_entry.hop = ((cost_q != 10'd0) || b_i_self) ? 4'(b_i_r) : 4'd0;
      reb_entry.dis = 11'(cost_q);
    end
  end

  always_comb begin
    fresh = '0;
    if (c_i_r != '0) begin
      if (c_i_self) begin
        fresh.hop = 4'(c_i_r);
      end else if (best_r != dvrt_pkg::DIST_INF) begin
        fresh.hop = 4'(hop_r);
        fresh.dis = 11'(best_r);
      end
    end
  end

  always_comb begin
    vec_we   = 1'b0;
    vec_wa   = cnt_r;
    vec_wd   = '0;
    vec_re   = 1'b0;
    vec_ra   = {a_j, a_i};
    cost_we  = 1'b0;
    cost_wa  = cnt_lo;
    cost_wd  = '0;
    cost_re  = 1'b0;
    cost_ra  = (rebuild || j_zero) ? a_i : a_j;
    route_we = 1'b0;
    route_wa = cnt_lo;
    route_wd = '0;
    route_re = 1'b0;
    route_ra = a_i;
    case (cmd.op)
      dvrt_pkg::OP_CLEAR: begin
        vec_we   = 1'b1;
        cost_we  = 1'b1;
        route_we = 1'b1;
      end
      dvrt_pkg::OP_LOAD: begin
        vec_we = nb_ok && dst_ok;
        vec_wa = {nb_idx, dst_idx};
        vec_wd = vd_r;
      end
      dvrt_pkg::OP_COST_RD: begin
        cost_re = 1'b1;
        cost_ra = nb_idx;
      end
      dvrt_pkg::OP_COST_WR: begin
        cost_we = !upd_skip;
        cost_wa = nb_idx;
        cost_wd = drop ? 10'd0 : wt_r;
      end
      dvrt_pkg::OP_ROW: begin
        vec_we = 1'b1;
        vec_wa = {nb_idx, cnt_lo};
        vec_wd = (drop || (cnt_lo == nb_idx)) ? 12'sd0 : -12'sd1;
      end
      dvrt_pkg::OP_SWEEP: begin
        cost_re  = 1'b1;
        vec_re   = !rebuild;
        route_re = !rebuild && j_zero;
      end
      dvrt_pkg::OP_READ: begin
        route_re = 1'b1;
        route_ra = dst_idx;
      end
      default: begin
        vec_we = 1'b0;
      end
    endcase
    if (b_v_r && rebuild) begin
      route_we = 1'b1;
      route_wa = b_i_r;
      route_wd = reb_entry;
    end
    if (c_v_r) begin
      route_we = 1'b1;
      route_wa = c_i_r;
      route_wd = fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= vec_wd;
    end
    if (vec_re) begin
      vec_q <= vec_mem[vec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    if (cost_re) begin
      cost_q <= cost_mem[cost_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_wa] <= route_wd;
    end
    if (route_re) begin
      route_q <= route_mem[route_ra];
    end
  end

  always_comb begin
    best_nxt = best_r;
    hop_nxt  = hop_r;
    old_nxt  = old_r;
    if (b_v_r && !rebuild) begin
      if (b_j_r == '0) begin
        best_nxt = (cost_q != 10'd0) ? {2'b00, cost_q} : dvrt_pkg::DIST_INF;
        hop_nxt  = (cost_q != 10'd0) ? b_i_r : '0;
        old_nxt  = route_q.dis;
      end else if ((cost_q != 10'd0) && (vec_q > 12'sd0) && (b_j_r != b_i_r) && !b_j_self
                   && (cand < best_r)) begin
        best_nxt = cand;
        hop_nxt  = b_j_r;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    changed_nxt = changed_r;
    if (cmd.capture) begin
      changed_nxt = 1'b0;
    end else if (c_v_r && (fresh.dis != old_r)) begin
      changed_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      b_v_r       <= sweep;
      c_v_r       <= b_v_r && !rebuild && (b_j_r == '1);
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= dvrt_pkg::cmd_t'(in_command);
      nb_r  <= in_neighbor_index;
      dst_r <= in_dest_index;
      vd_r  <= in_vector_distance;
      wt_r  <= in_link_weight;
    end
    b_i_r  <= a_i;
    b_j_r  <= a_j;
    c_i_r  <= b_i_r;
    best_r <= best_nxt;
    hop_r  <= hop_nxt;
    old_r  <= old_nxt;
    if (cmd.out_load) begin
      out_changed_r  <= (cmd_r == dvrt_pkg::CMD_RECOMP) && changed_r;
      out_next_hop_r <= ((cmd_r == dvrt_pkg::CMD_READ) && dst_ok) ? route_q.hop : 4'd0;
      out_distance_r <= ((cmd_r == dvrt_pkg::CMD_READ) && dst_ok) ? route_q.dis : 11'd0;
    end
  end

  assign stat.cnt_last_row = (cnt_lo == '1);
  assign stat.cnt_last_all = (cnt_r == '1);
  assign stat.upd_skip     = upd_skip;
  assign stat.pipe_busy    = b_v_r || c_v_r;
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_changed  = out_changed_r;
  assign out_next_hop = out_next_hop_r;
  assign out_distance = out_distance_r;

endmodule

// ===== sv/distance_vector_route_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the distance-vector route table: configuration register, controller and datapath.
// Depends on dvrt_pkg, dvrt_ctrl and dvrt_dpath.
//
//   Channel   Direction  Handshake            Content
//   in_*      input      in_valid / in_stall  command, neighbor, destination, distance, weight
//   out_*     output     out_valid/out_stall  changed flag, next hop, distance
//   APB       input      psel/penable/pready  self_index at byte address 0
//
// Load and read take a single working state; a link update reads, then writes the link cost
// and, if the link changes, rewrites the neighbor's vector row and rebuilds the P direct routes;
// a recompute sweeps all P*P vector entries, where P is NODE_COUNT rounded up to a power of two;
// recompute reads one vector entry a cycle. After reset a clearing pass zeroes all memories
// while in_stall stays high. One transaction is worked on at a time; a finished result waits in
// the output register under out_stall while the next transaction is accepted.
module distance_vector_route_table_core #(
  parameter int NODE_COUNT = dvrt_pkg::NODE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [3:0]                          in_neighbor_index,
  input  logic [3:0]                          in_dest_index,
  input  logic signed [11:0]                  in_vector_distance,
  input  logic [9:0]                          in_link_weight,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_changed,
  output logic [3:0]                          out_next_hop,
  output logic [10:0]                         out_distance,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dvrt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [3:0]          self_r;
  logic [3:0]          self_nxt;
  logic                self_sel;
  dvrt_pkg::dp_cmd_t   cmd;
  dvrt_pkg::dp_stat_t  stat;

  assign pready   = 1'b1;
  assign self_sel = (paddr[2] == dvrt_pkg::REG_SELF_INDEX);
  assign self_nxt = (psel && penable && pwrite && pready && self_sel) ? pwdata[3:0] : self_r;
  assign prdata   = self_sel ? {28'd0, self_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r <= dvrt_pkg::SELF_INDEX_RESET;
    end else begin
      self_r <= self_nxt;
    end
  end

  dvrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  dvrt_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .self_index         (self_r),
    .in_command         (in_command),
    .in_neighbor_index  (in_neighbor_index),
    .in_dest_index      (in_dest_index),
    .in_vector_distance (in_vector_distance),
    .in_link_weight     (in_link_weight),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_changed        (out_changed),
    .out_next_hop       (out_next_hop),
    .out_distance       (out_distance)
  );

endmodule

// ===== dv/distance_vector_route_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for distance_vector_route_table_core: random command traffic and APB
// writes, each reply checked field by field against an in-bench route table predictor.
// Depends on dvrt_pkg and the distance_vector_route_table_core RTL.
module distance_vector_route_table_core_tb;

  localparam int NODES = dvrt_pkg::NODE_COUNT_DEF;
  localparam int IDLE_PCT = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam logic [dvrt_pkg::CFG_ADDR_W-1:0] SELF_INDEX_ADDR = {dvrt_pkg::REG_SELF_INDEX, 2'b00};

  typedef struct packed {
    logic        changed;
    logic [3:0]  hop;
    logic [10:0] dis;
  } route_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = dvrt_pkg::CMD_LOAD;
  logic [3:0] in_neighbor_index = '0;
  logic [3:0] in_dest_index = '0;
  logic signed [11:0] in_vector_distance = '0;
  logic [9:0] in_link_weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_changed;
  logic [3:0] out_next_hop;
  logic [10:0] out_distance;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dvrt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic steady_flow = 1'b0;
  int commands_sent = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  route_reply_t expected_replies[$];

  logic [3:0] self_idx = dvrt_pkg::SELF_INDEX_RESET;
  logic [9:0] link_cost_m [NODES] = '{default: '0};
  logic signed [11:0] heard_vec [NODES][NODES] = '{default: '{default: '0}};
  dvrt_pkg::route_t routes [NODES] = '{default: '0};

  distance_vector_route_table_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_neighbor_index(in_neighbor_index),
    .in_dest_index(in_dest_index),
    .in_vector_distance(in_vector_distance),
    .in_link_weight(in_link_weight),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_changed(out_changed),
    .out_next_hop(out_next_hop),
    .out_distance(out_distance),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void rebuild_direct_routes();
    int i;
    for (i = 0; i < NODES; i++) routes[i] = '0;
    for (i = 1; i < NODES; i++) begin
      if (i == int'(self_idx)) routes[i].hop = 4'(i);
      if (link_cost_m[i] != 0) begin
        routes[i].hop = 4'(i);
        routes[i].dis = 11'(link_cost_m[i]);
      end
    end
  endfunction

  function automatic void apply_link_update(logic [3:0] nb, logic [9:0] w);
    int i;
    if (w == 0 || w > dvrt_pkg::MAX_LINK_COST) begin
      if (link_cost_m[nb] == 0) return;
      link_cost_m[nb] = '0;
      for (i = 0; i < NODES; i++) heard_vec[nb][i] = '0;
    end else begin
      if (w == link_cost_m[nb]) return;
      link_cost_m[nb] = w;
      for (i = 1; i < NODES; i++) heard_vec[nb][i] = (i == int'(nb)) ? 12'sd0 : -12'sd1;
    end
    rebuild_direct_routes();
  endfunction

  function automatic logic bellman_ford_pass();
    dvrt_pkg::route_t fresh [NODES];
    int i, j, best, via_cost;
    logic [3:0] hop;
    logic changed;
    changed = 1'b0;
    for (i = 0; i < NODES; i++) fresh[i] = '0;
    for (i = 1; i < NODES; i++) begin
      if (i == int'(self_idx)) begin
        fresh[i].hop = 4'(i);
        continue;
      end
      best = int'(dvrt_pkg::DIST_INF);
      hop = '0;
      if (link_cost_m[i] != 0) begin
        best = int'(link_cost_m[i]);
        hop = 4'(i);
      end
      for (j = 1; j < NODES; j++) begin
        if (link_cost_m[j] != 0 && j != i && j != int'(self_idx) && heard_vec[j][i] > 0) begin
          via_cost = int'(link_cost_m[j]) + int'(heard_vec[j][i]);
          if (via_cost < best) begin
            best = via_cost;
            hop = 4'(j);
          end
        end
      end
      if (best != int'(dvrt_pkg::DIST_INF)) begin
        fresh[i].hop = hop;
        fresh[i].dis = 11'(best);
      end
    end
    for (i = 1; i < NODES; i++) begin
      if (fresh[i].dis != routes[i].dis) changed = 1'b1;
    end
    for (i = 0; i < NODES; i++) routes[i] = fresh[i];
    return changed;
  endfunction

  function automatic route_reply_t predict_reply(dvrt_pkg::cmd_t cmd, logic [3:0] nb,
                                                 logic [3:0] dest, logic signed [11:0] vd,
                                                 logic [9:0] w);
    route_reply_t reply;
    reply = '0;
    case (cmd)
      dvrt_pkg::CMD_LOAD: heard_vec[nb][dest] = vd;
      dvrt_pkg::CMD_UPDATE: apply_link_update(nb, w);
      dvrt_pkg::CMD_RECOMP: reply.changed = bellman_ford_pass();
      default: begin
        reply.hop = routes[dest].hop;
        reply.dis = routes[dest].dis;
      end
    endcase
    return reply;
  endfunction

  function automatic logic signed [11:0] random_vector_distance();
    return 12'($urandom_range(2048) - 1);
  endfunction

  task automatic send_command(input dvrt_pkg::cmd_t cmd, input logic [3:0] nb,
                              input logic [3:0] dest, input logic signed [11:0] vd,
                              input logic [9:0] w);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_neighbor_index <= nb;
    in_dest_index <= dest;
    in_vector_distance <= vd;
    in_link_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_replies.push_back(predict_reply(cmd, nb, dest, vd, w));
    commands_sent++;
  endtask

  task automatic send_random_command();
    send_command(dvrt_pkg::cmd_t'($urandom_range(3)), 4'($urandom_range(15)),
                 4'($urandom_range(15)), random_vector_distance(), 10'($urandom_range(1023)));
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_self_index(input logic [3:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SELF_INDEX_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    self_idx = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd0, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd1, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd15, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_RECOMP, 4'd0, 4'd0, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd1, 12'sd0, 10'd0);
  endtask

  task automatic test_link_edges();
    send_command(dvrt_pkg::CMD_UPDATE, 4'd3, 4'd0, 12'sd0, 10'd1);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd15, 4'd0, 12'sd0, 10'd1000);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd15, 4'd0, 12'sd0, 10'd1000);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd3, 4'd0, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd3, 4'd0, 12'sd0, 10'd1001);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd0, 4'd0, 12'sd0, 10'd5);
    send_command(dvrt_pkg::CMD_UPDATE, 4'd9, 4'd0, 12'sd0, 10'd1023);
  endtask

  task automatic test_vector_extremes();
    send_command(dvrt_pkg::CMD_UPDATE, 4'd2, 4'd0, 12'sd0, 10'd10);
    send_command(dvrt_pkg::CMD_LOAD, 4'd2, 4'd4, 12'sd2047, 10'd0);
    send_command(dvrt_pkg::CMD_LOAD, 4'd2, 4'd5, -12'sd1, 10'd0);
    send_command(dvrt_pkg::CMD_LOAD, 4'd2, 4'd6, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_LOAD, 4'd2, 4'd7, 12'sd1, 10'd0);
    send_command(dvrt_pkg::CMD_LOAD, 4'd15, 4'd7, 12'sd1, 10'd0);
    send_command(dvrt_pkg::CMD_RECOMP, 4'd0, 4'd0, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd4, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd5, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd7, 12'sd0, 10'd0);
    send_command(dvrt_pkg::CMD_READ, 4'd0, 4'd15, 12'sd0, 10'd0);
  endtask

  // Links are set first, then vectors are heard over them, so the pass has real relays to weigh.
  task automatic run_route_scenario();
    logic [3:0] peers [5];
    logic [9:0] w;
    logic signed [11:0] vd;
    int n_peers, k, n_loads, n_reads;
    n_peers = $urandom_range(5, 1);
    for (k = 0; k < n_peers; k++) begin
      peers[k] = ($urandom_range(15) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
      case ($urandom_range(9))
        0: w = ($urandom_range(1) == 0) ? 10'd1 : 10'd1000;
        1: w = ($urandom_range(1) == 0) ? 10'd0 : 10'($urandom_range(1023, 1001));
        default: w = 10'($urandom_range(300, 1));
      endcase
      send_command(dvrt_pkg::CMD_UPDATE, peers[k], 4'($urandom_range(15)),
                   random_vector_distance(), w);
    end
    n_loads = $urandom_range(12, 3);
    for (k = 0; k < n_loads; k++) begin
      case ($urandom_range(19))
        0: vd = -12'sd1;
        1: vd = 12'sd0;
        2: vd = 12'sd2047;
        3: vd = 12'($urandom_range(2047, 1000));
        default: vd = 12'($urandom_range(500, 1));
      endcase
      send_command(dvrt_pkg::CMD_LOAD, peers[$urandom_range(n_peers - 1)],
                   4'($urandom_range(15)), vd, 10'($urandom_range(1023)));
    end
    send_command(dvrt_pkg::CMD_RECOMP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                 random_vector_distance(), 10'($urandom_range(1023)));
    if ($urandom_range(9) < 3)
      send_command(dvrt_pkg::CMD_RECOMP, 4'd0, 4'd0, 12'sd0, 10'd0);
    n_reads = ($urandom_range(9) == 0) ? NODES : $urandom_range(6, 2);
    for (k = 0; k < n_reads; k++) begin
      send_command(dvrt_pkg::CMD_READ, 4'($urandom_range(15)),
                   (n_reads == NODES) ? 4'(k) : 4'($urandom_range(15)),
                   random_vector_distance(), 10'($urandom_range(1023)));
    end
  endtask

  task automatic test_random_traffic(input logic [3:0] self_value, input int budget,
                                     input logic no_gaps);
    int target;
    drain_replies();
    write_self_index(self_value);
    steady_flow <= no_gaps;
    target = commands_sent + budget;
    while (commands_sent < target) begin
      if ($urandom_range(99) < 25) send_random_command();
      else run_route_scenario();
    end
  endtask

  always @(posedge clk) out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);

  always @(posedge clk) begin
    route_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none expected: changed=%0d next_hop=%0d distance=%0d",
                 $time, out_changed, out_next_hop, out_distance);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_changed !== want.changed) begin
          $display("%0t: changed expected %0d actual %0d", $time, want.changed, out_changed);
          mismatch_count++;
        end
        if (out_next_hop !== want.hop) begin
          $display("%0t: next_hop expected %0d actual %0d", $time, want.hop, out_next_hop);
          mismatch_count++;
        end
        if (out_distance !== want.dis) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.dis, out_distance);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL distance_vector_route_table_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_link_edges();
    test_vector_extremes();
    test_random_traffic(4'd15, 350, 1'b0);
    test_random_traffic(4'd0, 200, 1'b0);
    test_random_traffic(4'd1, 350, 1'b1);
    test_random_traffic(4'($urandom_range(14, 2)), 400, 1'b0);
    test_random_traffic(4'($urandom_range(14, 2)), 400, 1'b0);
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("PASS distance_vector_route_table_core");
    else
      $display("FAIL distance_vector_route_table_core");
    $finish;
  end

endmodule
